// ===== hw/rtl/aidr_pkg.sv =====
// Shared types and constants for the alias / node-id registry table.
// Holds the entry record, per-cell control struct, operation and state codes.
// No dependencies; every other file of the block imports this package.
package aidr_pkg;

  localparam int ALIAS_W     = 16;
  localparam int NODE_W      = 64;
  localparam int STATUS_W    = 4;
  localparam int KIND_W      = 3;
  localparam int COUNT_OUT_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 96;

  localparam logic [STATUS_W-1:0] STATUS_CODE_RST  = 4'h0;
  localparam logic [NODE_W-1:0]   PREFIX_MASK_RST  = 64'hFFFF_FF00_0000_0000;
  localparam logic [NODE_W-1:0]   PREFIX_VALUE_RST = 64'h0201_1200_0000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD        = 3'd0,
    KIND_LOOKUP_AL  = 3'd1,
    KIND_LOOKUP_ND  = 3'd2,
    KIND_REMOVE     = 3'd3,
    KIND_SET_STATUS = 3'd4,
    KIND_SET_NODE   = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATUS_CODE  = 2'd0,
    CFG_PREFIX_MASK  = 2'd1,
    CFG_PREFIX_VALUE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [ALIAS_W-1:0]  alias_id;
    logic [NODE_W-1:0]   node_id;
    logic [STATUS_W-1:0] status;
  } entry_t;

  typedef struct packed {
    logic sample;      // capture key match flags
    logic load;        // write a whole new entry
    logic shift;       // take the upper neighbor's entry
    logic set_status;  // overwrite the status only
    logic set_node;    // overwrite the node id only
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/aidr_cell.sv =====
// One slot of the registry chain: stores an entry, matches it against the keys
// and the registered-prefix rule, and can take its upper neighbor's entry.
// Depends on aidr_pkg.
module aidr_cell
  import aidr_pkg::*;
(
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                valid_in,
  input  entry_t              wr_entry,
  input  entry_t              upper_entry,
  input  logic [ALIAS_W-1:0]  key_alias,
  input  logic [NODE_W-1:0]   key_node,
  input  logic [STATUS_W-1:0] reg_status,
  input  logic [NODE_W-1:0]   reg_mask,
  input  logic [NODE_W-1:0]   reg_value,
  output entry_t              entry,
  output logic                alias_hit,
  output logic                node_hit,
  output logic                prefix_hit
);

  entry_t entry_r;
  logic   alias_hit_r;
  logic   node_hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.sample) begin
      alias_hit_r <= valid_in && (entry_r.alias_id == key_alias);
      node_hit_r  <= valid_in && (entry_r.node_id == key_node);
    end
    if (ctrl.load) begin
      entry_r <= wr_entry;
    end else if (ctrl.shift) begin
      entry_r <= upper_entry;
    end else begin
      if (ctrl.set_status) begin
        entry_r.status <= wr_entry.status;
      end
      if (ctrl.set_node) begin
        entry_r.node_id <= wr_entry.node_id;
      end
    end
  end

  assign entry      = entry_r;
  assign alias_hit  = alias_hit_r;
  assign node_hit   = node_hit_r;
  assign prefix_hit = valid_in && (entry_r.status == reg_status) &&
                      ((entry_r.node_id & reg_mask) == reg_value);

endmodule

// ===== hw/rtl/alias_id_registry_table.sv =====
// Alias / node-id registry: a packed chain of TABLE_DEPTH cells, one per entry.
// The sequencer walks each item through the cell chain in turn: accept, compare,
// update, prefix scan. A new item is taken only once the last result has moved
// into the output register, which a stalled output can hold off.
// Reset (synchronous, rst_n low) empties the table and loads the default
// registered-prefix rule; entry storage itself is not cleared.
module alias_id_registry_table
  import aidr_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, low bit up: alias_req[15:0], node_id[79:16], new_status[83:80], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: kind[2:0]
  input  logic [KIND_W-1:0]      in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, low bit up: ok[0], found_alias[16:1], found_node_id[80:17],
  // found_status[84:81], entry_count[89:85], registered_present[90], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Index width for the cell chain, and a count width that can hold the depth.
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers for the registered-prefix check.
  logic [STATUS_W-1:0] reg_status_r;
  logic [NODE_W-1:0]   reg_mask_r;
  logic [NODE_W-1:0]   reg_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_status_r <= STATUS_CODE_RST;
      reg_mask_r   <= PREFIX_MASK_RST;
      reg_value_r  <= PREFIX_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STATUS_CODE:  reg_status_r <= cfg_wdata[STATUS_W-1:0];
        CFG_PREFIX_MASK:  reg_mask_r   <= cfg_wdata;
        CFG_PREFIX_VALUE: reg_value_r  <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Sequencer state and the captured input transaction.
  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r;
  entry_t              req_r;
  logic [CW-1:0]       count_r, count_nxt;

  // Result held between the update step and the output register.
  logic                res_ok_r, res_ok_nxt;
  logic [ALIAS_W-1:0]  res_alias_r, res_alias_nxt;
  logic [NODE_W-1:0]   res_node_r, res_node_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic in_fire;
  logic out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // The finished result moves out when the output register is free or being drained.
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Cell chain wiring.
  cell_ctrl_t             cell_ctrl [TABLE_DEPTH];
  entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] alias_hits;
  logic [TABLE_DEPTH-1:0] node_hits;
  logic [TABLE_DEPTH-1:0] prefix_hits;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t upper;
    // The top cell has no neighbor above; a shift keeps its own entry, now past the valid range.
    if (k == TABLE_DEPTH - 1) begin : g_top
      assign upper = cell_entry[k];
    end else begin : g_mid
      assign upper = cell_entry[k+1];
    end

    assign cell_valid[k] = (CW'(k) < count_r);

    aidr_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[k]),
      .valid_in    (cell_valid[k]),
      .wr_entry    (req_r),
      .upper_entry (upper),
      .key_alias   (req_r.alias_id),
      .key_node    (req_r.node_id),
      .reg_status  (reg_status_r),
      .reg_mask    (reg_mask_r),
      .reg_value   (reg_value_r),
      .entry       (cell_entry[k]),
      .alias_hit   (alias_hits[k]),
      .node_hit    (node_hits[k]),
      .prefix_hit  (prefix_hits[k])
    );
  end

  // Lowest matching cell. Node-id look-up searches the node flags; every other
  // operation keys on the alias.
  logic [TABLE_DEPTH-1:0] sel_hits;
  logic [IW-1:0]          sel_idx;
  logic                   sel_any;
  entry_t                 sel_entry;
  logic                   is_upd;
  logic                   add_ok;
  logic                   rem_ok;

  assign sel_hits  = (kind_r == KIND_LOOKUP_ND) ? node_hits : alias_hits;
  assign sel_any   = |sel_hits;
  assign sel_entry = cell_entry[sel_idx];
  assign is_upd    = (state_r == ST_UPD);
  assign add_ok    = (kind_r == KIND_ADD) && (count_r < CW'(TABLE_DEPTH)) &&
                     !(|alias_hits) && !(|node_hits);
  assign rem_ok    = (kind_r == KIND_REMOVE) && sel_any;

  always_comb begin
    sel_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (sel_hits[k]) begin
        sel_idx = IW'(k);
      end
    end
  end

  // Per-cell controls. During the update step an add writes the first free
  // cell, a remove pulls every cell at or above the hit down by one, and the
  // two setters touch only the hit cell.
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      cell_ctrl[k].sample     = (state_r == ST_CMP);
      cell_ctrl[k].load       = is_upd && add_ok && (CW'(k) == count_r);
      cell_ctrl[k].shift      = is_upd && rem_ok && (IW'(k) >= sel_idx);
      cell_ctrl[k].set_status = is_upd && (kind_r == KIND_SET_STATUS) && sel_any &&
                                (IW'(k) == sel_idx);
      cell_ctrl[k].set_node   = is_upd && (kind_r == KIND_SET_NODE) && sel_any &&
                                (IW'(k) == sel_idx);
    end
  end

  // Result of the operation and the new entry count.
  always_comb begin
    res_ok_nxt     = 1'b0;
    res_alias_nxt  = '0;
    res_node_nxt   = '0;
    res_status_nxt = '0;
    count_nxt      = count_r;
    case (kind_t'(kind_r)) inside
      KIND_ADD: begin
        res_ok_nxt = add_ok;
        if (add_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_LOOKUP_AL: begin
        res_ok_nxt = sel_any;
        if (sel_any) begin
          res_node_nxt   = sel_entry.node_id;
          res_status_nxt = sel_entry.status;
        end
      end
      KIND_LOOKUP_ND: begin
        res_ok_nxt = sel_any;
        if (sel_any) begin
          res_alias_nxt = sel_entry.alias_id;
        end
      end
      KIND_REMOVE: begin
        res_ok_nxt = rem_ok;
        if (rem_ok) begin
          count_nxt = count_r - CW'(1);
        end
      end
      KIND_SET_STATUS, KIND_SET_NODE: begin
        res_ok_nxt = sel_any;
      end
      default: ;  // undefined operation codes change nothing and report not ok
    endcase
  end

  // Sequencer: compare, update, then scan the prefix rule over the new table.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (is_upd) begin
        count_r <= count_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r         <= in_tuser;
      req_r.alias_id <= in_tdata[15:0];
      req_r.node_id  <= in_tdata[79:16];
      req_r.status   <= in_tdata[83:80];
    end
    if (is_upd) begin
      res_ok_r     <= res_ok_nxt;
      res_alias_r  <= res_alias_nxt;
      res_node_r   <= res_node_nxt;
      res_status_r <= res_status_nxt;
    end
    if (out_load) begin
      out_data_r <= {5'b0, |prefix_hits, COUNT_OUT_W'(count_r), res_status_r,
                     res_node_r, res_alias_r, res_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/aidr_checker.sv =====
// Port-level checks for the registry table, bound to the top level by the bind below.
// Depends on aidr_pkg and on the port list of alias_id_registry_table.
module aidr_checker
  import aidr_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_we
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in flight");

  // A failed operation never reports found data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      (out_tdata[16:1] == '0) && (out_tdata[80:17] == '0) && (out_tdata[84:81] == '0))
    else $error("found fields set on a failed operation");

  // The reported count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (TABLE_DEPTH > 31) || (int'(out_tdata[89:85]) <= TABLE_DEPTH))
    else $error("entry count above table depth");

  // The prefix rule is only rewritten while no transaction is being worked on.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_tready)
    else $error("configuration written while an item is in flight");

endmodule

bind alias_id_registry_table aidr_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_aidr_checker (.*);

// ===== sim/alias_id_registry_table_tb.sv =====
// Self-checking testbench for the alias / node-id registry table.
// Depends on aidr_pkg (widths, operation codes, register indexes) and the
// alias_id_registry_table RTL; nothing else is read at run time.
module alias_id_registry_table_tb;
  import aidr_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  // Idle wait after the last result is back, with margin on top of the pipeline.
  localparam int PIPE_SETTLE  = 6;
  localparam int HOLD_CYCLES  = 160;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // The tuser field is three bits wide, so two codes exist beyond the
  // defined operations. The block must treat them as no-ops.
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  // One result transaction. Members run from the top bit down, so the
  // packed struct lines up with out_tdata[90:0] with ok in bit 0.
  typedef struct packed {
    logic                   reg_present;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [STATUS_W-1:0]    found_status;
    logic [NODE_W-1:0]      found_node;
    logic [ALIAS_W-1:0]     found_alias;
    logic                   ok;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  alias_id_registry_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the registry. It mirrors the packed table: valid entries
  // always sit at indices 0 .. tbl_count-1, and nothing above that is read.
  // ---------------------------------------------------------------------
  logic [ALIAS_W-1:0]  tbl_alias  [TABLE_DEPTH];
  logic [NODE_W-1:0]   tbl_node   [TABLE_DEPTH];
  logic [STATUS_W-1:0] tbl_status [TABLE_DEPTH];
  int                  tbl_count = 0;

  // Shadow copy of the registered-prefix rule, starting from reset values.
  logic [STATUS_W-1:0] rule_status = STATUS_CODE_RST;
  logic [NODE_W-1:0]   rule_mask   = PREFIX_MASK_RST;
  logic [NODE_W-1:0]   rule_value  = PREFIX_VALUE_RST;

  answer_t pending_answers[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_trigger   = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int checked_count  = 0;
  int items_sent     = 0;
  int full_refusals  = 0;
  int rule_settings  = 1;

  // Searches return the lowest matching index, or -1 when nothing matches.
  function automatic int find_alias(logic [ALIAS_W-1:0] key);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_alias[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_node(logic [NODE_W-1:0] node);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_node[i] == node) return i;
    return -1;
  endfunction

  function automatic logic registered_client_seen();
    for (int i = 0; i < tbl_count; i++)
      if (tbl_status[i] == rule_status && (tbl_node[i] & rule_mask) == rule_value)
        return 1'b1;
    return 1'b0;
  endfunction

  // Applies one operation to the shadow table and returns the answer the
  // block must give for it. The count and prefix flag are taken after the
  // operation has changed the table.
  function automatic answer_t registry_apply(logic [KIND_W-1:0] op,
                                             logic [ALIAS_W-1:0] key,
                                             logic [NODE_W-1:0] node,
                                             logic [STATUS_W-1:0] st);
    answer_t ans;
    int      idx;
    ans = '0;
    case (op)
      KIND_ADD: begin
        if (tbl_count == TABLE_DEPTH) begin
          full_refusals++;
        end else if (find_alias(key) < 0 && find_node(node) < 0) begin
          tbl_alias[tbl_count]  = key;
          tbl_node[tbl_count]   = node;
          tbl_status[tbl_count] = st;
          tbl_count++;
          ans.ok = 1'b1;
        end
      end
      KIND_LOOKUP_AL: begin
        idx = find_alias(key);
        if (idx >= 0) begin
          ans.ok           = 1'b1;
          ans.found_node   = tbl_node[idx];
          ans.found_status = tbl_status[idx];
        end
      end
      KIND_LOOKUP_ND: begin
        idx = find_node(node);
        if (idx >= 0) begin
          ans.ok          = 1'b1;
          ans.found_alias = tbl_alias[idx];
        end
      end
      KIND_REMOVE: begin
        idx = find_alias(key);
        if (idx >= 0) begin
          // Later entries slide down one place to keep the table packed.
          for (int j = idx; j < tbl_count - 1; j++) begin
            tbl_alias[j]  = tbl_alias[j+1];
            tbl_node[j]   = tbl_node[j+1];
            tbl_status[j] = tbl_status[j+1];
          end
          tbl_count--;
          ans.ok = 1'b1;
        end
      end
      KIND_SET_STATUS: begin
        idx = find_alias(key);
        if (idx >= 0) begin
          tbl_status[idx] = st;
          ans.ok = 1'b1;
        end
      end
      KIND_SET_NODE: begin
        // No duplicate check here: two entries may end up with one node id.
        idx = find_alias(key);
        if (idx >= 0) begin
          tbl_node[idx] = node;
          ans.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ans.entry_count = tbl_count[COUNT_OUT_W-1:0];
    ans.reg_present = registered_client_seen();
    return ans;
  endfunction

  // ---------------------------------------------------------------------
  // Result side. The receiver either idles at random or, when a test asks
  // for it, holds tready low for a long counted stretch so that the block
  // backs up and stops taking input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_trigger != hold_served) begin
      hold_served <= hold_trigger;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = answer_t'(out_tdata[$bits(answer_t)-1:0]);
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0d] unexpected result transaction: %p", cycle_count, got);
      end else begin
        want = pending_answers.pop_front();
        checked_count++;
        if (got.ok !== want.ok || got.found_alias !== want.found_alias ||
            got.found_node !== want.found_node ||
            got.found_status !== want.found_status ||
            got.entry_count !== want.entry_count ||
            got.reg_present !== want.reg_present) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("[%0d] result %0d mismatch", cycle_count, checked_count);
            $display("  expected ok=%0b alias=%h node=%h status=%h count=%0d reg=%0b",
                     want.ok, want.found_alias, want.found_node, want.found_status,
                     want.entry_count, want.reg_present);
            $display("  actual   ok=%0b alias=%h node=%h status=%h count=%0d reg=%0b",
                     got.ok, got.found_alias, got.found_node, got.found_status,
                     got.entry_count, got.reg_present);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run instead of spinning forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_answers.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Input side. send_op offers one transaction and returns at the edge
  // where it was taken; tvalid stays high when the next item follows
  // straight away, so it is never lowered and raised in one step.
  // ---------------------------------------------------------------------
  task automatic send_op(logic [KIND_W-1:0] op, logic [ALIAS_W-1:0] key,
                         logic [NODE_W-1:0] node, logic [STATUS_W-1:0] st);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-ALIAS_W-NODE_W-STATUS_W){1'b0}}, st, node, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // Accepted at this edge; the rule registers cannot change while items
    // are in flight, so the answer can be worked out right now.
    pending_answers.push_back(registry_apply(op, key, node, st));
    items_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  // Pause the input until every expected result has come back, then let
  // the pipeline settle so the block is fully idle.
  task automatic wait_quiet();
    stop_sending();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Programs all three rule registers back to back while the block is idle.
  task automatic set_rules(logic [CFG_DATA_W-1:0] status_word,
                           logic [NODE_W-1:0] mask, logic [NODE_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STATUS_CODE;
    cfg_wdata <= status_word;
    @(posedge clk);
    cfg_index <= CFG_PREFIX_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_PREFIX_VALUE;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // Only the low nibble of the status word is kept by the block.
    rule_status = status_word[STATUS_W-1:0];
    rule_mask   = mask;
    rule_value  = value;
    rule_settings++;
  endtask

  function automatic logic [NODE_W-1:0] random_node();
    return {$urandom(), $urandom()};
  endfunction

  // Node ids for add and set-node: many land on the registered prefix so
  // the flag toggles, some repeat a stored id to provoke duplicate refusals.
  function automatic logic [NODE_W-1:0] candidate_node();
    int r;
    r = $urandom_range(99);
    if (r < 30) return (rule_value & rule_mask) | (random_node() & ~rule_mask);
    if (r < 45 && tbl_count > 0) return tbl_node[$urandom_range(0, tbl_count - 1)];
    if (r < 47) return '0;
    if (r < 49) return '1;
    return random_node();
  endfunction

  // Alias keys: stored ones at the given percentage, else a small range that collides
  // often, else anything in the 16-bit space.
  function automatic logic [ALIAS_W-1:0] candidate_key(int stored_pct);
    if (tbl_count > 0 && $urandom_range(99) < stored_pct)
      return tbl_alias[$urandom_range(0, tbl_count - 1)];
    if ($urandom_range(99) < 20) return ALIAS_W'($urandom_range(0, 15));
    return ALIAS_W'($urandom_range(0, 65535));
  endfunction

  // Random traffic in fill and drain sweeps: while filling, adds dominate
  // until the table is full and refuses; then removes dominate until it is
  // empty again. Look-ups and updates aim mostly at stored entries.
  task automatic drive_traffic(int n_items);
    logic                  filling;
    logic [KIND_W-1:0]     op;
    logic [ALIAS_W-1:0]    key;
    logic [NODE_W-1:0]     node;
    logic [STATUS_W-1:0]   st;
    int                    r;
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (tbl_count == TABLE_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (tbl_count == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (filling) begin
        if (r < 50)      op = KIND_ADD;
        else if (r < 60) op = KIND_LOOKUP_AL;
        else if (r < 70) op = KIND_LOOKUP_ND;
        else if (r < 78) op = KIND_REMOVE;
        else if (r < 86) op = KIND_SET_STATUS;
        else if (r < 95) op = KIND_SET_NODE;
        else             op = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
      end else begin
        if (r < 15)      op = KIND_ADD;
        else if (r < 30) op = KIND_LOOKUP_AL;
        else if (r < 40) op = KIND_LOOKUP_ND;
        else if (r < 75) op = KIND_REMOVE;
        else if (r < 85) op = KIND_SET_STATUS;
        else if (r < 95) op = KIND_SET_NODE;
        else             op = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
      end
      key  = candidate_key(op == KIND_ADD ? 10 : 80);
      node = candidate_node();
      // Look-ups by node id mostly ask for a stored one.
      if (op == KIND_LOOKUP_ND && tbl_count > 0 && $urandom_range(99) < 70)
        node = tbl_node[$urandom_range(0, tbl_count - 1)];
      st = ($urandom_range(99) < 45) ? rule_status : STATUS_W'($urandom_range(0, 15));
      send_op(op, key, node, st);
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed tests. The table starts empty after reset and the default
  // registered-prefix rule is in force.
  // ---------------------------------------------------------------------
  task automatic test_empty_table();
    // Every search misses on an empty table.
    send_op(KIND_LOOKUP_AL, 16'hFFFF, '0, '0);
    send_op(KIND_LOOKUP_ND, 16'h0000, '0, '0);
    send_op(KIND_REMOVE, 16'h0000, '0, '0);
    send_op(KIND_SET_STATUS, 16'h0001, '1, 4'hF);
    send_op(KIND_SET_NODE, 16'h0001, '1, 4'hF);
  endtask

  task automatic test_add_extremes();
    send_op(KIND_ADD, 16'h0000, 64'h0, 4'h0);
    send_op(KIND_ADD, 16'hFFFF, '1, 4'hF);
    // Status 0 and the default prefix: this entry raises the flag.
    send_op(KIND_ADD, 16'h1234, 64'h0201_1200_0000_0042, 4'h0);
    send_op(KIND_LOOKUP_AL, 16'hFFFF, '0, '0);
    send_op(KIND_LOOKUP_ND, 16'hABCD, 64'h0, '0);
  endtask

  task automatic test_duplicates_and_updates();
    // Adds are refused on a repeated alias and on a repeated node id.
    send_op(KIND_ADD, 16'h0000, 64'h1, 4'h2);
    send_op(KIND_ADD, 16'h5555, '1, 4'h2);
    // Set-node may duplicate a node id; the lower entry then wins searches.
    send_op(KIND_SET_NODE, 16'h0000, '1, '0);
    send_op(KIND_LOOKUP_ND, 16'h0000, '1, '0);
    // Moving the registered entry off the qualifying status drops the flag.
    send_op(KIND_SET_STATUS, 16'h1234, '0, 4'h3);
  endtask

  task automatic test_unknown_kinds();
    send_op(KIND_SPARE_6, 16'h0000, '1, 4'hF);
    send_op(KIND_SPARE_7, 16'hFFFF, '1, 4'hF);
  endtask

  task automatic test_remove_compaction();
    // Removing the first entry shifts both later entries down.
    send_op(KIND_REMOVE, 16'h0000, '0, '0);
    send_op(KIND_LOOKUP_ND, 16'h0000, '1, '0);
    send_op(KIND_LOOKUP_AL, 16'h1234, '0, '0);
    send_op(KIND_REMOVE, 16'h1234, '0, '0);
    send_op(KIND_REMOVE, 16'h1234, '0, '0);
    stop_sending();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
    drive_traffic(n_items);
    stop_sending();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // items back to back; the block must fill up and hold off its input
  // without losing or reordering anything. Then the sender waits for the
  // table's answers to drain completely.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_trigger <= hold_trigger + 1;
    drive_traffic(30);
    wait_quiet();
  endtask

  initial begin : run
    logic [CFG_DATA_W-1:0] status_word;
    logic [NODE_W-1:0]     mask_word;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_extremes();
    test_duplicates_and_updates();
    test_unknown_kinds();
    test_remove_compaction();

    // Top extremes: status 15 (upper bits of the word are junk the block
    // must drop), full mask, all-ones prefix.
    status_word = {$urandom(), $urandom()};
    status_word[STATUS_W-1:0] = 4'hF;
    set_rules(status_word, '1, '1);
    test_random_traffic(460, 28, 78);
    test_backpressure();

    // Bottom extremes: with an empty mask every status-0 entry qualifies.
    set_rules('0, '0, '0);
    test_random_traffic(460, 78, 28);

    // A middle setting: random status and a random prefix under a 20-bit mask.
    mask_word = 64'hFFFF_F000_0000_0000;
    set_rules(CFG_DATA_W'($urandom_range(0, 15)), mask_word, random_node() & mask_word);
    test_random_traffic(460, 0, 0);

    wait_quiet();
    $display("Covered %0d operations under %0d prefix rules, %0d answers checked,",
             items_sent, rule_settings, checked_count);
    $display("with %0d adds refused on a full table and one long result stall.",
             full_refusals);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
